/* rtl/core/dlcfs_pkg.sv */
// ----------------------------------------------------------------------------
// dlcfs_pkg
// Shared widths, register indexes, status codes and types for the dual
// load cell factor solver.
// ----------------------------------------------------------------------------
package dlcfs_pkg;

  localparam int WEIGHT_W    = 16;
  localparam int LIMIT_W     = 31;
  localparam int EPS_W       = 16;
  localparam int CFG_DATA_W  = 31;
  localparam int CFG_IDX_W   = 2;
  localparam int FACTOR_W    = 32;
  localparam int STATUS_W    = 2;
  localparam int NET_MIN_ABS = 10000;
  localparam int FIFO_DEPTH  = 2;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);

  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FMIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FMAX   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EPS    = 2'd3;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 16'd155;
  localparam logic [LIMIT_W-1:0]  FMIN_RST   = 31'd0;
  localparam logic [LIMIT_W-1:0]  FMAX_RST   = 31'h7fff_ffff;
  localparam logic [EPS_W-1:0]    EPS_RST    = 16'd655;

  typedef enum logic [STATUS_W-1:0] {
    ST_SOLVED    = 2'd0,
    ST_FALLBACK  = 2'd1,
    ST_NET_SMALL = 2'd2,
    ST_RANGE     = 2'd3
  } status_e;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [LIMIT_W-1:0]  fmin;
    logic [LIMIT_W-1:0]  fmax;
    logic [EPS_W-1:0]    eps;
  } cfg_t;

  typedef struct packed {
    logic [FACTOR_W:0] q;
    logic              fail;
  } div_res_t;

endpackage

/* rtl/core/dlcfs_if.sv */
// ----------------------------------------------------------------------------
// dlcfs_in_if / dlcfs_out_if
// Valid/ready channels carrying the four net readings and the solved factors.
// ----------------------------------------------------------------------------
interface dlcfs_in_if #(
  parameter int NET_BITS = 25
);
  logic                       valid;
  logic                       ready;
  logic signed [NET_BITS-1:0] left_net_weight_left;
  logic signed [NET_BITS-1:0] right_net_weight_left;
  logic signed [NET_BITS-1:0] left_net_weight_right;
  logic signed [NET_BITS-1:0] right_net_weight_right;

  modport source (
    output valid, left_net_weight_left, right_net_weight_left,
           left_net_weight_right, right_net_weight_right,
    input  ready
  );
  modport sink (
    input  valid, left_net_weight_left, right_net_weight_left,
           left_net_weight_right, right_net_weight_right,
    output ready
  );
endinterface

interface dlcfs_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [dlcfs_pkg::FACTOR_W-1:0] factor_left;
  logic signed [dlcfs_pkg::FACTOR_W-1:0] factor_right;
  logic [dlcfs_pkg::STATUS_W-1:0]       status;

  modport source (
    output valid, factor_left, factor_right, status,
    input  ready
  );
  modport sink (
    input  valid, factor_left, factor_right, status,
    output ready
  );
endinterface

/* rtl/core/dlcfs_front.sv */
// ----------------------------------------------------------------------------
// dlcfs_front
// Accepts readings, forms differences and magnitudes, flags small nets.
// ----------------------------------------------------------------------------
module dlcfs_front #(
  parameter int NET_BITS = 25
) (
  dlcfs_in_if.sink                in_i,
  input  logic                    full_i,
  output logic                    push_o,
  output logic [8*NET_BITS+2:0]   ent_o
);

  localparam int N = NET_BITS;

  typedef struct packed {
    logic signed [N-1:0] a;
    logic signed [N-1:0] b;
    logic signed [N-1:0] c;
    logic signed [N-1:0] d;
    logic signed [N:0]   nl;
    logic signed [N:0]   nr;
    logic [N-1:0]        mag_a;
    logic [N-1:0]        mag_d;
    logic                net_small;
  } ent_t;

  ent_t ent;

  always_comb begin
    ent.a         = in_i.left_net_weight_left;
    ent.b         = in_i.right_net_weight_left;
    ent.c         = in_i.left_net_weight_right;
    ent.d         = in_i.right_net_weight_right;
    ent.nl        = (N+1)'(ent.d) - (N+1)'(ent.b);
    ent.nr        = (N+1)'(ent.a) - (N+1)'(ent.c);
    ent.mag_a     = ent.a[N-1] ? (N)'(-ent.a) : ent.a;
    ent.mag_d     = ent.d[N-1] ? (N)'(-ent.d) : ent.d;
    ent.net_small = (ent.mag_a < N'(dlcfs_pkg::NET_MIN_ABS)) ||
                    (ent.mag_d < N'(dlcfs_pkg::NET_MIN_ABS));
  end

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;
  assign ent_o      = ent;

endmodule

/* rtl/core/dlcfs_fifo.sv */
// ----------------------------------------------------------------------------
// dlcfs_fifo
// Short queue between the front and the solver.
// ----------------------------------------------------------------------------
module dlcfs_fifo #(
  parameter int WIDTH = 203
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PW = dlcfs_pkg::FIFO_PTR_W;

  logic [WIDTH-1:0] mem_q [dlcfs_pkg::FIFO_DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [PW:0]      cnt_q, cnt_d;

  assign full_o  = cnt_q == (PW+1)'(dlcfs_pkg::FIFO_DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? ((wr_q == PW'(dlcfs_pkg::FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = pop_i  ? ((rd_q == PW'(dlcfs_pkg::FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

/* rtl/core/dlcfs_div.sv */
// ----------------------------------------------------------------------------
// dlcfs_div
// Bit-serial restoring divider, one quotient bit per step_i cycle, round half up.
// ----------------------------------------------------------------------------
module dlcfs_div #(
  parameter int NUM_W = 66,
  parameter int DEN_W = 51
) (
  input  logic                  clk_i,
  input  logic                  load_i,
  input  logic                  step_i,
  input  logic [NUM_W-1:0]      num_i,
  input  logic [DEN_W-1:0]      den_i,
  output dlcfs_pkg::div_res_t   res_o
);

  localparam int QW    = dlcfs_pkg::FACTOR_W;
  localparam int REM_W = DEN_W + 1;

  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den_q;
  logic [REM_W-1:0] rem_q, rem_sh;
  logic [QW-1:0]    q_q;
  logic             ovf_q, ge, rnd;

  assign rem_sh = {rem_q[REM_W-2:0], num_q[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};
  assign rnd    = {rem_q[REM_W-2:0], 1'b0} >= {1'b0, den_q};

  assign res_o.q    = {1'b0, q_q} + (QW+1)'(rnd);
  assign res_o.fail = ovf_q || (den_q == '0);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      q_q   <= '0;
      ovf_q <= 1'b0;
    end else if (step_i) begin
      num_q <= {num_q[NUM_W-2:0], 1'b0};
      rem_q <= ge ? rem_sh - {1'b0, den_q} : rem_sh;
      q_q   <= {q_q[QW-2:0], ge};
      ovf_q <= ovf_q | q_q[QW-1];
    end
  end

endmodule

/* rtl/core/dlcfs_back.sv */
// ----------------------------------------------------------------------------
// dlcfs_back
// Solver: products, determinant test, four dividers, result selection.
// ----------------------------------------------------------------------------
module dlcfs_back #(
  parameter int NET_BITS         = 25,
  parameter int FACTOR_FRAC_BITS = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dlcfs_pkg::cfg_t       cfg_i,
  input  logic                  empty_i,
  input  logic [8*NET_BITS+2:0] ent_i,
  output logic                  pop_o,
  dlcfs_out_if.source           out_o
);

  localparam int N     = NET_BITS;
  localparam int F     = FACTOR_FRAC_BITS;
  localparam int P_W   = 2 * N;
  localparam int DET_W = 2 * N + 1;
  localparam int X_W   = N + 1 + dlcfs_pkg::WEIGHT_W;
  localparam int NUM_W = X_W + F;
  localparam int CMP_W = DET_W + dlcfs_pkg::EPS_W;
  localparam int CNT_W = $clog2(NUM_W);
  localparam int FW    = dlcfs_pkg::FACTOR_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_PREP = 3'd2;
  localparam logic [2:0] S_LOAD = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  typedef struct packed {
    logic signed [N-1:0] a;
    logic signed [N-1:0] b;
    logic signed [N-1:0] c;
    logic signed [N-1:0] d;
    logic signed [N:0]   nl;
    logic signed [N:0]   nr;
    logic [N-1:0]        mag_a;
    logic [N-1:0]        mag_d;
    logic                net_small;
  } ent_t;

  ent_t ent_q;
  logic [2:0]             state_q, state_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic signed [P_W-1:0]  p1_q, p2_q;
  logic [X_W-1:0]         xl_q, xr_q;
  logic [DET_W-1:0]       detm_q;
  logic                   detneg_q;
  logic [P_W-1:0]         ref_q;
  logic [CMP_W-1:0]       refeps_q;
  logic signed [DET_W-1:0] det;
  logic [P_W-1:0]         mp1, mp2;
  logic [N:0]             mnl, mnr;

  logic                   ovalid_q, ovalid_d;
  logic [FW-1:0]          ofl_q, ofr_q, ofl_d, ofr_d;
  dlcfs_pkg::status_e     ost_q, ost_d;

  dlcfs_pkg::div_res_t    rcl, rcr, rfl, rfr;
  logic                   div_load, div_step, fin_fire, det_small;
  logic                   okcl, okcr, okfl, okfr;
  logic [FW:0]            fmin_x, fmax_x;

  function automatic logic [FW-1:0] apply_sign(logic [FW:0] q, logic neg);
    logic [FW-1:0] v;
    v = q[FW-1:0];
    return neg ? FW'(-v) : v;
  endfunction

  assign mnl = ent_q.nl[N] ? (N+1)'(-ent_q.nl) : ent_q.nl;
  assign mnr = ent_q.nr[N] ? (N+1)'(-ent_q.nr) : ent_q.nr;
  assign det = DET_W'(p1_q) - DET_W'(p2_q);
  assign mp1 = p1_q[P_W-1] ? P_W'(-p1_q) : p1_q;
  assign mp2 = p2_q[P_W-1] ? P_W'(-p2_q) : p2_q;

  assign div_load = state_q == S_LOAD;
  assign div_step = state_q == S_DIV;
  assign pop_o    = (state_q == S_IDLE) && !empty_i;
  assign fin_fire = (state_q == S_FIN) && (!ovalid_q || out_o.ready);

  dlcfs_div #(.NUM_W(NUM_W), .DEN_W(DET_W)) u_div_cl (
    .clk_i, .load_i(div_load), .step_i(div_step),
    .num_i(NUM_W'(xl_q) << F), .den_i(detm_q), .res_o(rcl)
  );
  dlcfs_div #(.NUM_W(NUM_W), .DEN_W(DET_W)) u_div_cr (
    .clk_i, .load_i(div_load), .step_i(div_step),
    .num_i(NUM_W'(xr_q) << F), .den_i(detm_q), .res_o(rcr)
  );
  dlcfs_div #(.NUM_W(NUM_W), .DEN_W(DET_W)) u_div_fl (
    .clk_i, .load_i(div_load), .step_i(div_step),
    .num_i(NUM_W'(cfg_i.weight) << F), .den_i(DET_W'(ent_q.mag_a)), .res_o(rfl)
  );
  dlcfs_div #(.NUM_W(NUM_W), .DEN_W(DET_W)) u_div_fr (
    .clk_i, .load_i(div_load), .step_i(div_step),
    .num_i(NUM_W'(cfg_i.weight) << F), .den_i(DET_W'(ent_q.mag_d)), .res_o(rfr)
  );

  always_comb begin
    fmin_x    = (FW+1)'(cfg_i.fmin);
    fmax_x    = (FW+1)'(cfg_i.fmax);
    det_small = (ref_q <= P_W'(1)) ||
                ({detm_q, {dlcfs_pkg::EPS_W{1'b0}}} < refeps_q);
    okcl   = !rcl.fail && (rcl.q <= fmax_x) && (rcl.q >= fmin_x);
    okcr   = !rcr.fail && (rcr.q <= fmax_x) && (rcr.q >= fmin_x);
    okfl   = !rfl.fail && (rfl.q <= fmax_x) && (rfl.q >= fmin_x);
    okfr   = !rfr.fail && (rfr.q <= fmax_x) && (rfr.q >= fmin_x);
    if (!det_small && okcl && okcr) begin
      ost_d = dlcfs_pkg::ST_SOLVED;
      ofl_d = apply_sign(rcl.q, ent_q.nl[N] ^ detneg_q);
      ofr_d = apply_sign(rcr.q, ent_q.nr[N] ^ detneg_q);
    end else if (ent_q.net_small) begin
      ost_d = dlcfs_pkg::ST_NET_SMALL;
      ofl_d = '0;
      ofr_d = '0;
    end else if (okfl && okfr) begin
      ost_d = dlcfs_pkg::ST_FALLBACK;
      ofl_d = apply_sign(rfl.q, ent_q.a[N-1]);
      ofr_d = apply_sign(rfr.q, ent_q.d[N-1]);
    end else begin
      ost_d = dlcfs_pkg::ST_RANGE;
      ofl_d = '0;
      ofr_d = '0;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (!empty_i) state_d = S_MUL;
      end
      S_MUL:  state_d = S_PREP;
      S_PREP: state_d = S_LOAD;
      S_LOAD: begin
        state_d = S_DIV;
        cnt_d   = '0;
      end
      S_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(NUM_W - 1)) state_d = S_FIN;
      end
      S_FIN: begin
        if (fin_fire) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    ovalid_d = fin_fire ? 1'b1 : (out_o.ready ? 1'b0 : ovalid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) ent_q <= ent_i;
    if (state_q == S_MUL) begin
      p1_q <= P_W'(ent_q.a) * P_W'(ent_q.d);
      p2_q <= P_W'(ent_q.c) * P_W'(ent_q.b);
      xl_q <= X_W'(cfg_i.weight) * X_W'(mnl);
      xr_q <= X_W'(cfg_i.weight) * X_W'(mnr);
    end
    if (state_q == S_PREP) begin
      detneg_q <= det[DET_W-1];
      detm_q   <= det[DET_W-1] ? DET_W'(-det) : det;
      ref_q    <= mp1 + mp2;
    end
    if (state_q == S_LOAD) begin
      refeps_q <= CMP_W'(ref_q) * CMP_W'(cfg_i.eps);
    end
    if (fin_fire) begin
      ofl_q <= ofl_d;
      ofr_q <= ofr_d;
      ost_q <= ost_d;
    end
  end

  assign out_o.valid        = ovalid_q;
  assign out_o.factor_left  = ofl_q;
  assign out_o.factor_right = ofr_q;
  assign out_o.status       = ost_q;

endmodule

/* rtl/core/dual_load_cell_factor_solver_top.sv */
// ----------------------------------------------------------------------------
// dual_load_cell_factor_solver_top
// Solves the two load cell factors of a dual cell scale by Cramer's rule,
// with per-side division as fallback. One result per item, signed Q8.24.
// The bit-serial dividers, with NUM_W = NET_BITS + 17 + FACTOR_FRAC_BITS
// numerator bits, set the solver's pace and produce one quotient bit per cycle.
// A two-entry queue, the solver's entry register and the output register let
// up to four items be in flight; input is taken while the queue has room,
// regardless of the solver or the output side.
// ----------------------------------------------------------------------------
module dual_load_cell_factor_solver_top #(
  parameter int NET_BITS         = 25,
  parameter int FACTOR_FRAC_BITS = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dlcfs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dlcfs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  dlcfs_in_if.sink                         in_i,
  dlcfs_out_if.source                      out_o
);

  localparam int ENT_W = 8 * NET_BITS + 3;

  dlcfs_pkg::cfg_t  cfg_q;
  logic             push, pop, full, empty;
  logic [ENT_W-1:0] ent_in, ent_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.weight <= dlcfs_pkg::WEIGHT_RST;
      cfg_q.fmin   <= dlcfs_pkg::FMIN_RST;
      cfg_q.fmax   <= dlcfs_pkg::FMAX_RST;
      cfg_q.eps    <= dlcfs_pkg::EPS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dlcfs_pkg::REG_WEIGHT: cfg_q.weight <= cfg_data_i[dlcfs_pkg::WEIGHT_W-1:0];
        dlcfs_pkg::REG_FMIN:   cfg_q.fmin   <= cfg_data_i[dlcfs_pkg::LIMIT_W-1:0];
        dlcfs_pkg::REG_FMAX:   cfg_q.fmax   <= cfg_data_i[dlcfs_pkg::LIMIT_W-1:0];
        dlcfs_pkg::REG_EPS:    cfg_q.eps    <= cfg_data_i[dlcfs_pkg::EPS_W-1:0];
        default: ;
      endcase
    end
  end

  dlcfs_front #(.NET_BITS(NET_BITS)) u_front (
    .in_i, .full_i(full), .push_o(push), .ent_o(ent_in)
  );

  dlcfs_fifo #(.WIDTH(ENT_W)) u_fifo (
    .clk_i, .rst_ni, .push_i(push), .data_i(ent_in), .pop_i(pop),
    .data_o(ent_out), .full_o(full), .empty_o(empty)
  );

  dlcfs_back #(.NET_BITS(NET_BITS), .FACTOR_FRAC_BITS(FACTOR_FRAC_BITS)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .empty_i(empty), .ent_i(ent_out),
    .pop_o(pop), .out_o
  );

endmodule

/* rtl/core/dlcfs_checker.sv */
// ----------------------------------------------------------------------------
// dlcfs_checker
// Port-level checks on the solver's channels, bound to the top level.
// ----------------------------------------------------------------------------
module dlcfs_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_i,
  input logic                                out_valid_i,
  input logic                                out_ready_i,
  input logic [dlcfs_pkg::FACTOR_W-1:0]      factor_left_i,
  input logic [dlcfs_pkg::FACTOR_W-1:0]      factor_right_i,
  input logic [dlcfs_pkg::STATUS_W-1:0]      status_i
);

  localparam logic [2:0] MAX_INFLIGHT = 3'(dlcfs_pkg::FIFO_DEPTH + 2);

  logic [2:0] cnt_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + 3'(in_acc) - 3'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(factor_left_i) &&
      $stable(factor_right_i) && $stable(status_i))
    else $error("result changed while stalled");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == dlcfs_pkg::ST_NET_SMALL || status_i == dlcfs_pkg::ST_RANGE)
      |-> factor_left_i == '0 && factor_right_i == '0)
    else $error("failure status with nonzero factors");

  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cnt_q != '0)
    else $error("result without an outstanding item");

  a_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MAX_INFLIGHT)
    else $error("more items in flight than storage");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i)
    else $error("result valid out of reset");

endmodule

bind dual_load_cell_factor_solver_top dlcfs_checker u_dlcfs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .factor_left_i  (out_o.factor_left),
  .factor_right_i (out_o.factor_right),
  .status_i       (out_o.status)
);
